FILE: design/slcm_pkg.sv
`default_nettype none
package slcm_pkg;

    localparam int NUM_LEDS = 4;
    localparam int REG_IDX_W = 3;

    typedef logic [3:0] mode_t;

    localparam mode_t MODE_ERROR        = 4'd1;
    localparam mode_t MODE_KEYBOARD     = 4'd2;
    localparam mode_t MODE_TOUCH        = 4'd3;
    localparam mode_t MODE_CAPSLOCK     = 4'd4;
    localparam mode_t MODE_BREATH_RED   = 4'd5;
    localparam mode_t MODE_BREATH_GREEN = 4'd6;
    localparam mode_t MODE_BREATH_BLUE  = 4'd7;
    localparam mode_t MODE_FAN          = 4'd8;
    localparam mode_t MODE_BACKLIGHT    = 4'd9;
    localparam mode_t MODE_RANDOM       = 4'd10;
    localparam mode_t MODE_BATTERY      = 4'd11;

    localparam logic [REG_IDX_W-1:0] REG_LED0_MODE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LED1_MODE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LED2_MODE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LED3_MODE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BREATH_PEAK = 3'd4;

    localparam logic [7:0] PEAK_RESET  = 8'd50;
    localparam logic [7:0] LEVEL_HIGH  = 8'd80;
    localparam logic [7:0] LEVEL_LOW   = 8'd20;
    localparam logic [7:0] COLOR_ON    = 8'd10;
    localparam logic [3:0] FADE_START  = 4'd10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        mode_t [NUM_LEDS-1:0] mode;
        logic [7:0]           peak;
    } cfg_t;

    typedef struct packed {
        logic [7:0] battery_level;
        logic       error_flag;
        logic       keyboard_activity;
        logic       touch_activity;
        logic       capslock_on;
        logic [7:0] fan_level;
        logic [7:0] backlight_level;
    } status_t;

    // per-tick animation values handed from the state unit to the palette
    typedef struct packed {
        logic [7:0] breath;
        rgb_t       keyboard_rgb;
        rgb_t       touch_rgb;
    } anim_t;

    localparam rgb_t RGB_BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0};
    localparam rgb_t RGB_RED   = '{red: COLOR_ON, green: 8'd0, blue: 8'd0};
    localparam rgb_t RGB_GREEN = '{red: 8'd0, green: COLOR_ON, blue: 8'd0};
    localparam rgb_t RGB_BLUE  = '{red: 8'd0, green: 8'd0, blue: COLOR_ON};

    // exact for any 8-bit value: x / 10 == (x * 205) >> 11 below 1029
    function automatic logic [7:0] div10(input logic [7:0] v);
        logic [15:0] prod;
        prod = 16'(v) * 16'd205;
        return 8'(prod >> 11);
    endfunction

    function automatic rgb_t level_rgb(input logic [7:0] v);
        rgb_t c;
        if (v >= LEVEL_HIGH) begin
            c = RGB_RED;
        end
        else if (v == 8'd0) begin
            c = RGB_BLUE;
        end
        else begin
            c = '{red: 8'd0, green: div10(v), blue: 8'd0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: design/slcm_cfg.sv
`default_nettype none
module slcm_cfg
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [slcm_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data,
    output slcm_pkg::cfg_t                      cfg
);

    slcm_pkg::cfg_t cfg_reg;
    slcm_pkg::cfg_t cfg_next;
    slcm_pkg::mode_t wr_mode;
    logic            mode_ok;

    assign wr_mode = cfg_data[3:0];
    assign mode_ok = (wr_mode >= slcm_pkg::MODE_ERROR) && (wr_mode <= slcm_pkg::MODE_BATTERY);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                slcm_pkg::REG_LED0_MODE:
                begin
                    if (mode_ok)
                    begin
                        cfg_next.mode[0] = wr_mode;
                    end
                end
                slcm_pkg::REG_LED1_MODE:
                begin
                    if (mode_ok)
                    begin
                        cfg_next.mode[1] = wr_mode;
                    end
                end
                slcm_pkg::REG_LED2_MODE:
                begin
                    if (mode_ok)
                    begin
                        cfg_next.mode[2] = wr_mode;
                    end
                end
                slcm_pkg::REG_LED3_MODE:
                begin
                    if (mode_ok)
                    begin
                        cfg_next.mode[3] = wr_mode;
                    end
                end
                slcm_pkg::REG_BREATH_PEAK:
                begin
                    cfg_next.peak = cfg_data;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode[0] <= slcm_pkg::MODE_ERROR;
            cfg_reg.mode[1] <= slcm_pkg::MODE_KEYBOARD;
            cfg_reg.mode[2] <= slcm_pkg::MODE_TOUCH;
            cfg_reg.mode[3] <= slcm_pkg::MODE_CAPSLOCK;
            cfg_reg.peak    <= slcm_pkg::PEAK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: design/slcm_state.sv
`default_nettype none
module slcm_state
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire slcm_pkg::cfg_t cfg,
    input  wire logic           keyboard_activity,
    input  wire logic           touch_activity,
    output slcm_pkg::anim_t     anim
);

    logic [7:0] breath_reg;
    logic [7:0] breath_next;
    logic       rising_reg;
    logic       rising_next;
    logic [3:0] kbd_fade_reg;
    logic [3:0] kbd_fade_next;
    logic [3:0] tch_fade_reg;
    logic [3:0] tch_fade_next;
    logic       mid;
    logic       kbd_used;
    logic       tch_used;
    slcm_pkg::rgb_t kbd_rgb;
    slcm_pkg::rgb_t tch_rgb;

    // triangle counter step
    always_comb
    begin
        breath_next = breath_reg;
        rising_next = rising_reg;
        if (rising_reg)
        begin
            if (breath_reg >= cfg.peak)
            begin
                rising_next = 1'b0;
                breath_next = cfg.peak;
            end
            else
            begin
                breath_next = breath_reg + 8'd1;
            end
        end
        else
        begin
            if (breath_reg != 8'd0)
            begin
                breath_next = breath_reg - 8'd1;
            end
            else
            begin
                rising_next = 1'b1;
            end
        end
    end

    assign mid = (breath_next == (cfg.peak >> 1));

    always_comb
    begin
        kbd_used = 1'b0;
        tch_used = 1'b0;
        for (int i = 0; i < slcm_pkg::NUM_LEDS; i++)
        begin
            if (cfg.mode[i] == slcm_pkg::MODE_KEYBOARD)
            begin
                kbd_used = 1'b1;
            end
            if (cfg.mode[i] == slcm_pkg::MODE_TOUCH)
            begin
                tch_used = 1'b1;
            end
        end
    end

    // keyboard fade
    always_comb
    begin
        kbd_fade_next = kbd_fade_reg;
        kbd_rgb       = slcm_pkg::RGB_BLACK;
        if (kbd_used)
        begin
            if (keyboard_activity)
            begin
                kbd_fade_next = slcm_pkg::FADE_START;
                kbd_rgb       = slcm_pkg::RGB_BLUE;
            end
            else if (kbd_fade_reg != 4'd0)
            begin
                if (mid)
                begin
                    kbd_fade_next = kbd_fade_reg - 4'd1;
                end
                kbd_rgb = '{red: 8'd0, green: 8'd0, blue: 8'(kbd_fade_next)};
            end
            else
            begin
                kbd_rgb = slcm_pkg::RGB_GREEN;
            end
        end
    end

    // touch fade
    always_comb
    begin
        tch_fade_next = tch_fade_reg;
        tch_rgb       = slcm_pkg::RGB_BLACK;
        if (tch_used)
        begin
            if (touch_activity)
            begin
                tch_fade_next = slcm_pkg::FADE_START;
                tch_rgb       = slcm_pkg::RGB_BLUE;
            end
            else if (tch_fade_reg != 4'd0)
            begin
                if (mid)
                begin
                    tch_fade_next = tch_fade_reg - 4'd1;
                end
                tch_rgb = '{red: 8'd0, green: 8'd0, blue: 8'(tch_fade_next)};
            end
            else
            begin
                tch_rgb = slcm_pkg::RGB_GREEN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            breath_reg   <= 8'd0;
            rising_reg   <= 1'b1;
            kbd_fade_reg <= 4'd0;
            tch_fade_reg <= 4'd0;
        end
        else if (advance)
        begin
            breath_reg   <= breath_next;
            rising_reg   <= rising_next;
            kbd_fade_reg <= kbd_fade_next;
            tch_fade_reg <= tch_fade_next;
        end
    end

    assign anim.breath       = breath_next;
    assign anim.keyboard_rgb = kbd_rgb;
    assign anim.touch_rgb    = tch_rgb;

endmodule
`default_nettype wire

FILE: design/slcm_palette.sv
`default_nettype none
module slcm_palette
(
    input  wire slcm_pkg::status_t                 status,
    input  wire slcm_pkg::anim_t                   anim,
    input  wire slcm_pkg::cfg_t                    cfg,
    output slcm_pkg::rgb_t [slcm_pkg::NUM_LEDS-1:0] led
);

    slcm_pkg::rgb_t err_rgb;
    slcm_pkg::rgb_t caps_rgb;
    slcm_pkg::rgb_t fan_rgb;
    slcm_pkg::rgb_t bl_rgb;
    slcm_pkg::rgb_t batt_rgb;

    assign err_rgb  = status.error_flag  ? slcm_pkg::RGB_RED : slcm_pkg::RGB_GREEN;
    assign caps_rgb = status.capslock_on ? slcm_pkg::RGB_RED : slcm_pkg::RGB_GREEN;
    assign fan_rgb  = slcm_pkg::level_rgb(status.fan_level);
    assign bl_rgb   = slcm_pkg::level_rgb(status.backlight_level);

    always_comb
    begin
        if (status.battery_level >= slcm_pkg::LEVEL_HIGH)
        begin
            batt_rgb = slcm_pkg::RGB_GREEN;
        end
        else if (status.battery_level <= slcm_pkg::LEVEL_LOW)
        begin
            batt_rgb = slcm_pkg::RGB_RED;
        end
        else
        begin
            batt_rgb = '{red: 8'd0, green: 8'd0,
                         blue: slcm_pkg::div10(status.battery_level)};
        end
    end

    always_comb
    begin
        for (int i = 0; i < slcm_pkg::NUM_LEDS; i++)
        begin
            unique case (cfg.mode[i])
                slcm_pkg::MODE_ERROR:        led[i] = err_rgb;
                slcm_pkg::MODE_KEYBOARD:     led[i] = anim.keyboard_rgb;
                slcm_pkg::MODE_TOUCH:        led[i] = anim.touch_rgb;
                slcm_pkg::MODE_CAPSLOCK:     led[i] = caps_rgb;
                slcm_pkg::MODE_BREATH_RED:
                    led[i] = '{red: anim.breath, green: 8'd0, blue: 8'd0};
                slcm_pkg::MODE_BREATH_GREEN:
                    led[i] = '{red: 8'd0, green: anim.breath, blue: 8'd0};
                slcm_pkg::MODE_BREATH_BLUE:
                    led[i] = '{red: 8'd0, green: 8'd0, blue: anim.breath};
                slcm_pkg::MODE_FAN:          led[i] = fan_rgb;
                slcm_pkg::MODE_BACKLIGHT:    led[i] = bl_rgb;
                slcm_pkg::MODE_RANDOM:       led[i] = slcm_pkg::RGB_BLACK;
                slcm_pkg::MODE_BATTERY:      led[i] = batt_rgb;
                default:                     led[i] = slcm_pkg::RGB_BLACK;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: design/status_led_color_mapper_core.sv
`default_nettype none
// Maps one system status word per clock, while out_stall is low, to the colors of
// four LEDs. A word is taken into an input register, colored combinationally and
// held in an output register; the block sustains one word per cycle while out_stall
// is low. The breathing counter and the two fade levels are updated as a word moves
// from the input register to the output register.
// cfg_ready is always high; configuration is meant to be written while idle.
module status_led_color_mapper_core
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_valid,
    output wire logic                           cfg_ready,
    input  wire logic [slcm_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data,

    input  wire logic                           in_valid,
    output wire logic                           in_stall,
    input  wire logic [7:0]                     battery_level,
    input  wire logic                           error_flag,
    input  wire logic                           keyboard_activity,
    input  wire logic                           touch_activity,
    input  wire logic                           capslock_on,
    input  wire logic [7:0]                     fan_level,
    input  wire logic [7:0]                     backlight_level,

    output wire logic                           out_valid,
    input  wire logic                           out_stall,
    output wire logic [7:0]                     led0_red,
    output wire logic [7:0]                     led0_green,
    output wire logic [7:0]                     led0_blue,
    output wire logic [7:0]                     led1_red,
    output wire logic [7:0]                     led1_green,
    output wire logic [7:0]                     led1_blue,
    output wire logic [7:0]                     led2_red,
    output wire logic [7:0]                     led2_green,
    output wire logic [7:0]                     led2_blue,
    output wire logic [7:0]                     led3_red,
    output wire logic [7:0]                     led3_green,
    output wire logic [7:0]                     led3_blue
);

    slcm_pkg::cfg_t                          cfg;
    slcm_pkg::anim_t                         anim;
    slcm_pkg::rgb_t [slcm_pkg::NUM_LEDS-1:0] led_color;

    logic              in_full_reg;
    logic              in_full_next;
    slcm_pkg::status_t status_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    slcm_pkg::rgb_t [slcm_pkg::NUM_LEDS-1:0] led_reg;

    logic accept;
    logic advance;

    assign cfg_ready = 1'b1;

    // word moves from the input register to the output register
    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign in_full_next   = accept ? 1'b1 : (advance ? 1'b0 : in_full_reg);
    assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg.battery_level     <= battery_level;
            status_reg.error_flag        <= error_flag;
            status_reg.keyboard_activity <= keyboard_activity;
            status_reg.touch_activity    <= touch_activity;
            status_reg.capslock_on       <= capslock_on;
            status_reg.fan_level         <= fan_level;
            status_reg.backlight_level   <= backlight_level;
        end
        if (advance)
        begin
            led_reg <= led_color;
        end
    end

    slcm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slcm_state u_state
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .advance           (advance),
        .cfg               (cfg),
        .keyboard_activity (status_reg.keyboard_activity),
        .touch_activity    (status_reg.touch_activity),
        .anim              (anim)
    );

    slcm_palette u_palette
    (
        .status (status_reg),
        .anim   (anim),
        .cfg    (cfg),
        .led    (led_color)
    );

    assign out_valid  = out_valid_reg;
    assign led0_red   = led_reg[0].red;
    assign led0_green = led_reg[0].green;
    assign led0_blue  = led_reg[0].blue;
    assign led1_red   = led_reg[1].red;
    assign led1_green = led_reg[1].green;
    assign led1_blue  = led_reg[1].blue;
    assign led2_red   = led_reg[2].red;
    assign led2_green = led_reg[2].green;
    assign led2_blue  = led_reg[2].blue;
    assign led3_red   = led_reg[3].red;
    assign led3_green = led_reg[3].green;
    assign led3_blue  = led_reg[3].blue;

endmodule
`default_nettype wire

FILE: tb/sv/status_led_color_mapper_core_test.sv
`default_nettype none
module status_led_color_mapper_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import slcm_pkg::*;

    typedef rgb_t [NUM_LEDS-1:0] frame_t;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOW_MAX    = 10;
    localparam int HOLD_CYCLES = 300;

    // indexes that decode to no register, and mode codes outside the legal range
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam mode_t MODE_OFF  = 4'd0;
    localparam mode_t MODE_PAST = MODE_BATTERY + 4'd1;
    localparam mode_t MODE_TOP  = 4'd15;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    wire logic            cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;
    logic                 in_valid;
    wire logic            in_stall;
    logic [7:0]           battery_level;
    logic                 error_flag;
    logic                 keyboard_activity;
    logic                 touch_activity;
    logic                 capslock_on;
    logic [7:0]           fan_level;
    logic [7:0]           backlight_level;
    wire logic            out_valid;
    logic                 out_stall;
    wire logic [7:0]      led0_red, led0_green, led0_blue;
    wire logic [7:0]      led1_red, led1_green, led1_blue;
    wire logic [7:0]      led2_red, led2_green, led2_blue;
    wire logic [7:0]      led3_red, led3_green, led3_blue;

    status_led_color_mapper_core u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .battery_level     (battery_level),
        .error_flag        (error_flag),
        .keyboard_activity (keyboard_activity),
        .touch_activity    (touch_activity),
        .capslock_on       (capslock_on),
        .fan_level         (fan_level),
        .backlight_level   (backlight_level),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .led0_red          (led0_red),
        .led0_green        (led0_green),
        .led0_blue         (led0_blue),
        .led1_red          (led1_red),
        .led1_green        (led1_green),
        .led1_blue         (led1_blue),
        .led2_red          (led2_red),
        .led2_green        (led2_green),
        .led2_blue         (led2_blue),
        .led3_red          (led3_red),
        .led3_green        (led3_green),
        .led3_blue         (led3_blue)
    );

    // mirror of the block's registers and animation state
    mode_t      led_mode_m [NUM_LEDS];
    logic [7:0] peak_m;
    logic [7:0] breath_m;
    logic       breath_up_m;
    logic [3:0] kbd_fade_m;
    logic [3:0] touch_fade_m;

    frame_t expected_frames[$];

    int  cycle_count   = 0;
    int  error_count   = 0;
    int  words_sent    = 0;
    int  frames_seen   = 0;
    int  cfg_writes    = 0;
    int  stall_cycles  = 0;
    bit  tx_idle_on    = 1'b1;
    bit  rx_idle_on    = 1'b1;
    int  hold_seq      = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (in_valid && in_stall)
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_frames.size());
        $display("status_led_color_mapper_core_test: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic rgb_t make_rgb(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
        rgb_t c;
        c.red   = r;
        c.green = g;
        c.blue  = b;
        return c;
    endfunction

    function automatic rgb_t gauge_rgb(input logic [7:0] v);
        if (v >= 8'd80)
        begin
            return RGB_RED;
        end
        if (v == 8'd0)
        begin
            return RGB_BLUE;
        end
        return make_rgb(8'd0, v / 8'd10, 8'd0);
    endfunction

    // activity relights the fade; otherwise it dims one step per midpoint
    function automatic rgb_t fade_rgb(inout logic [3:0] lvl, input logic active,
                                      input logic mid);
        if (active)
        begin
            lvl = FADE_START;
            return RGB_BLUE;
        end
        if (lvl != 4'd0)
        begin
            if (mid)
            begin
                lvl = lvl - 4'd1;
            end
            return make_rgb(8'd0, 8'd0, {4'd0, lvl});
        end
        return RGB_GREEN;
    endfunction

    function automatic logic mode_in_use(input mode_t m);
        foreach (led_mode_m[i])
        begin
            if (led_mode_m[i] == m)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic reset_mirror();
        led_mode_m[0] = MODE_ERROR;
        led_mode_m[1] = MODE_KEYBOARD;
        led_mode_m[2] = MODE_TOUCH;
        led_mode_m[3] = MODE_CAPSLOCK;
        peak_m        = PEAK_RESET;
        breath_m      = 8'd0;
        breath_up_m   = 1'b1;
        kbd_fade_m    = 4'd0;
        touch_fade_m  = 4'd0;
    endtask

    task automatic mirror_cfg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] data);
        if (idx <= REG_LED3_MODE)
        begin
            if (data[3:0] >= MODE_ERROR && data[3:0] <= MODE_BATTERY)
            begin
                led_mode_m[idx] = data[3:0];
            end
        end
        else if (idx == REG_BREATH_PEAK)
        begin
            peak_m = data;
        end
    endtask

    task automatic predict_colors(input status_t s);
        rgb_t   kbd_c;
        rgb_t   touch_c;
        rgb_t   bat_c;
        frame_t f;
        logic   mid;

        if (breath_up_m)
        begin
            if (breath_m >= peak_m)
            begin
                breath_up_m = 1'b0;
                breath_m    = peak_m;
            end
            else
            begin
                breath_m = breath_m + 8'd1;
            end
        end
        else if (breath_m != 8'd0)
        begin
            breath_m = breath_m - 8'd1;
        end
        else
        begin
            breath_up_m = 1'b1;
        end
        mid = (breath_m == (peak_m >> 1));

        kbd_c   = RGB_BLACK;
        touch_c = RGB_BLACK;
        if (mode_in_use(MODE_KEYBOARD))
        begin
            kbd_c = fade_rgb(kbd_fade_m, s.keyboard_activity, mid);
        end
        if (mode_in_use(MODE_TOUCH))
        begin
            touch_c = fade_rgb(touch_fade_m, s.touch_activity, mid);
        end

        if (s.battery_level >= 8'd80)
        begin
            bat_c = RGB_GREEN;
        end
        else if (s.battery_level <= 8'd20)
        begin
            bat_c = RGB_RED;
        end
        else
        begin
            bat_c = make_rgb(8'd0, 8'd0, s.battery_level / 8'd10);
        end

        for (int i = 0; i < NUM_LEDS; i++)
        begin
            case (led_mode_m[i])
                MODE_ERROR:        f[i] = s.error_flag ? RGB_RED : RGB_GREEN;
                MODE_KEYBOARD:     f[i] = kbd_c;
                MODE_TOUCH:        f[i] = touch_c;
                MODE_CAPSLOCK:     f[i] = s.capslock_on ? RGB_RED : RGB_GREEN;
                MODE_BREATH_RED:   f[i] = make_rgb(breath_m, 8'd0, 8'd0);
                MODE_BREATH_GREEN: f[i] = make_rgb(8'd0, breath_m, 8'd0);
                MODE_BREATH_BLUE:  f[i] = make_rgb(8'd0, 8'd0, breath_m);
                MODE_FAN:          f[i] = gauge_rgb(s.fan_level);
                MODE_BACKLIGHT:    f[i] = gauge_rgb(s.backlight_level);
                MODE_BATTERY:      f[i] = bat_c;
                default:           f[i] = RGB_BLACK;
            endcase
        end
        expected_frames.push_back(f);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic flag_field(input int led, input string chan, input logic [7:0] want,
                              input logic [7:0] got);
        error_count++;
        if (error_count <= SHOW_MAX)
        begin
            $display("mismatch at result %0d: led%0d %s expected %0d, got %0d",
                     frames_seen, led, chan, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        frame_t got;
        frame_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got[0] = make_rgb(led0_red, led0_green, led0_blue);
            got[1] = make_rgb(led1_red, led1_green, led1_blue);
            got[2] = make_rgb(led2_red, led2_green, led2_blue);
            got[3] = make_rgb(led3_red, led3_green, led3_blue);
            if (expected_frames.size() == 0)
            begin
                error_count++;
                if (error_count <= SHOW_MAX)
                begin
                    $display("unexpected result word at cycle %0d", cycle_count);
                end
            end
            else
            begin
                want = expected_frames.pop_front();
                for (int i = 0; i < NUM_LEDS; i++)
                begin
                    if (got[i].red !== want[i].red)
                        flag_field(i, "red", want[i].red, got[i].red);
                    if (got[i].green !== want[i].green)
                        flag_field(i, "green", want[i].green, got[i].green);
                    if (got[i].blue !== want[i].blue)
                        flag_field(i, "blue", want[i].blue, got[i].blue);
                end
            end
            frames_seen++;
        end
    end

    // ---------------------------------------------------------------- receiver

    initial
    begin : rx_side
        int burst;
        int hold;
        int seen;
        burst = 0;
        hold  = 0;
        seen  = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != seen)
            begin
                seen = hold_seq;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(0, 4);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- driving

    task automatic send_status(input status_t s);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        battery_level     <= s.battery_level;
        error_flag        <= s.error_flag;
        keyboard_activity <= s.keyboard_activity;
        touch_activity    <= s.touch_activity;
        capslock_on       <= s.capslock_on;
        fan_level         <= s.fan_level;
        backlight_level   <= s.backlight_level;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_colors(s);
        words_sent++;
    endtask

    // lets the pipeline empty so that registers can be written safely
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        mirror_cfg(idx, data);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_modes(input mode_t m0, input mode_t m1, input mode_t m2,
                             input mode_t m3);
        write_reg(REG_LED0_MODE, {4'd0, m0});
        write_reg(REG_LED1_MODE, {4'd0, m1});
        write_reg(REG_LED2_MODE, {4'd0, m2});
        write_reg(REG_LED3_MODE, {4'd0, m3});
    endtask

    function automatic status_t make_status(input logic [7:0] bat, input logic err,
                                            input logic kbd, input logic tch,
                                            input logic caps, input logic [7:0] fan,
                                            input logic [7:0] bl);
        status_t s;
        s.battery_level     = bat;
        s.error_flag        = err;
        s.keyboard_activity = kbd;
        s.touch_activity    = tch;
        s.capslock_on       = caps;
        s.fan_level         = fan;
        s.backlight_level   = bl;
        return s;
    endfunction

    // levels cluster around the 20 and 80 thresholds and zero
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 4))
            0:       return 8'($urandom_range(15, 25));
            1:       return 8'($urandom_range(75, 85));
            2:       return 8'($urandom_range(0, 2));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic status_t random_status(input int act_odds);
        return make_status(pick_level(), 1'($urandom_range(0, 1)),
                           $urandom_range(1, act_odds) == 1,
                           $urandom_range(1, act_odds) == 1,
                           1'($urandom_range(0, 1)), pick_level(), pick_level());
    endfunction

    task automatic randomize_config();
        logic [7:0] data;
        for (int i = 0; i <= REG_LED3_MODE; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                data = 8'($urandom_range(0, 255));
            end
            else
            begin
                data = {4'($urandom_range(0, 15)),
                        4'($urandom_range(MODE_ERROR, MODE_BATTERY))};
            end
            write_reg(REG_IDX_W'(i), data);
        end
        case ($urandom_range(0, 5))
            0:       data = 8'd0;
            1:       data = 8'd255;
            2:       data = 8'd1;
            3:       data = 8'($urandom_range(0, 255));
            default: data = 8'($urandom_range(2, 24));
        endcase
        write_reg(REG_BREATH_PEAK, data);
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg(REG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                      8'($urandom_range(0, 255)));
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_modes();
        send_status(make_status(8'd50, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0));
        send_status(make_status(8'd50, 1'b1, 1'b1, 1'b0, 1'b1, 8'd0, 8'd0));
        send_status(make_status(8'd50, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0));
        send_status(make_status(8'd50, 1'b1, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0));
        send_status(make_status(8'd50, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0));
        wait_drained();
    endtask

    task automatic test_levels_and_breath();
        logic [7:0] sweep [11] = '{8'd0, 8'd1, 8'd9, 8'd10, 8'd20, 8'd21, 8'd79,
                                   8'd80, 8'd81, 8'd254, 8'd255};
        set_modes(MODE_FAN, MODE_BACKLIGHT, MODE_BATTERY, MODE_RANDOM);
        foreach (sweep[i])
        begin
            send_status(make_status(sweep[i], 1'b1, 1'b1, 1'b1, 1'b1, sweep[i],
                                    sweep[10 - i]));
        end
        wait_drained();
        set_modes(MODE_BREATH_RED, MODE_BREATH_GREEN, MODE_BREATH_BLUE, MODE_ERROR);
        write_reg(REG_BREATH_PEAK, 8'd3);
        repeat (9)
        begin
            send_status(random_status(2));
        end
        wait_drained();
    endtask

    task automatic test_config_guard();
        write_reg(REG_LED0_MODE, {4'd0, MODE_OFF});
        write_reg(REG_LED1_MODE, {4'd0, MODE_PAST});
        write_reg(REG_LED2_MODE, {4'd0, MODE_TOP});
        write_reg(REG_LED3_MODE, {4'hF, MODE_OFF});
        write_reg(REG_SPARE_LO, 8'hFF);
        write_reg(REG_SPARE_HI, {4'd0, MODE_FAN});
        write_reg(REG_LED3_MODE, {4'hA, MODE_FAN});
        repeat (4)
        begin
            send_status(random_status(2));
        end
        wait_drained();
    endtask

    task automatic test_fade();
        set_modes(MODE_KEYBOARD, MODE_TOUCH, MODE_KEYBOARD, MODE_BREATH_BLUE);
        // a zero peak puts the counter at its midpoint on every tick
        write_reg(REG_BREATH_PEAK, 8'd0);
        send_status(make_status(8'd50, 1'b0, 1'b1, 1'b1, 1'b0, 8'd5, 8'd5));
        repeat (14)
        begin
            send_status(make_status(8'd50, 1'b0, 1'b0, 1'b0, 1'b0, 8'd5, 8'd5));
        end
        wait_drained();
        write_reg(REG_BREATH_PEAK, 8'd2);
        send_status(make_status(8'd50, 1'b0, 1'b1, 1'b0, 1'b0, 8'd5, 8'd5));
        repeat (20)
        begin
            send_status(make_status(8'd50, 1'b0, 1'b0, 1'b0, 1'b0, 8'd5, 8'd5));
        end
        send_status(make_status(8'd50, 1'b0, 1'b0, 1'b1, 1'b0, 8'd5, 8'd5));
        repeat (30)
        begin
            send_status(random_status(40));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        bit tx_was;
        tx_was     = tx_idle_on;
        tx_idle_on = 1'b0;
        set_modes(MODE_BREATH_RED, MODE_KEYBOARD, MODE_BATTERY, MODE_FAN);
        write_reg(REG_BREATH_PEAK, 8'd5);
        hold_seq++;
        repeat (60)
        begin
            send_status(random_status(6));
        end
        wait_drained();
        tx_idle_on = tx_was;
    endtask

    task automatic test_random();
        int act_odds [5] = '{2, 30, 8, 60, 4};
        for (int p = 0; p < 5; p++)
        begin
            // the closing phase runs at full rate on both sides
            tx_idle_on = (p < 4);
            rx_idle_on = (p < 4);
            randomize_config();
            repeat (180)
            begin
                send_status(random_status(act_odds[p]));
            end
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        in_valid          <= 1'b0;
        battery_level     <= '0;
        error_flag        <= 1'b0;
        keyboard_activity <= 1'b0;
        touch_activity    <= 1'b0;
        capslock_on       <= 1'b0;
        fan_level         <= '0;
        backlight_level   <= '0;
        reset_mirror();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_modes();
        test_levels_and_breath();
        test_config_guard();
        test_fade();
        test_backpressure();
        test_random();

        wait_drained();
        $display("ran %0d status words through %0d register writes, input held off %0d cycles",
                 words_sent, cfg_writes, stall_cycles);
        $display("compared %0d color results, %0d field mismatches", frames_seen,
                 error_count);
        if (error_count == 0 && expected_frames.size() == 0)
        begin
            $display("status_led_color_mapper_core_test: done, clean");
        end
        else
        begin
            $display("status_led_color_mapper_core_test: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
